FILE: rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Types, constants and the CRC-16 byte step shared by the meter reply parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

    localparam int FRAME_LENGTH = 25;
    localparam int STORE_DEPTH  = FRAME_LENGTH - 1;
    localparam int CRC_END      = FRAME_LENGTH - 2;
    localparam int COUNT_W      = $clog2(FRAME_LENGTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [15:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
        logic [31:0] energy;
        logic [15:0] frequency;
        logic [15:0] power_factor;
        logic [15:0] alarm;
    } t_result;

    // reflected CRC-16, one byte, bit at a time
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrfp_frame_core.sv
// ----------------------------------------------------------------------------
// mrfp_frame_core
// Byte counter, running CRC and frame byte store; decodes the result word.
// ----------------------------------------------------------------------------
module mrfp_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    output mrfp_pkg::t_result o_result
);
    import mrfp_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [15:0]        r_crc;
    logic [15:0]        n_crc;
    logic [7:0]         r_store [STORE_DEPTH];
    logic               w_last;
    logic               w_store_wr;
    logic               w_ok;

    assign w_last     = (r_count == COUNT_W'(STORE_DEPTH));
    assign w_store_wr = i_step && (i_kind == KIND_BYTE) && !w_last;
    assign w_ok       = (r_crc == {i_byte, r_store[STORE_DEPTH-1]});

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (i_step) begin
            if (i_kind == KIND_TIMEOUT || w_last) begin
                n_count = '0;
                n_crc   = CRC_INIT;
            end else begin
                n_count = r_count + COUNT_W'(1);
                if (r_count < COUNT_W'(CRC_END)) begin
                    n_crc = crc16_byte(r_crc, i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_store[r_count] <= i_byte;
        end
    end

    always_comb begin
        o_result       = '0;
        o_result.valid = i_step && (i_kind == KIND_TIMEOUT || w_last);
        if (i_step && i_kind == KIND_BYTE && w_last && w_ok) begin
            o_result.ok           = 1'b1;
            o_result.voltage      = {r_store[3], r_store[4]};
            o_result.current      = {r_store[7], r_store[8], r_store[5], r_store[6]};
            o_result.power        = {r_store[11], r_store[12], r_store[9], r_store[10]};
            o_result.energy       = {r_store[15], r_store[16], r_store[13], r_store[14]};
            o_result.frequency    = {r_store[17], r_store[18]};
            o_result.power_factor = {r_store[19], r_store[20]};
            o_result.alarm        = {r_store[21], r_store[22]};
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STORE_DEPTH))
        else $error("byte count beyond frame store");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |=> (r_count == '0) && (r_crc == CRC_INIT))
        else $error("frame not restarted after result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_wr |=> r_count == $past(r_count) + COUNT_W'(1))
        else $error("byte count did not advance");
`endif

endmodule

FILE: rtl/meter_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// meter_reply_frame_parser
// Modbus RTU reply parser for an energy meter read-input-registers response.
// ----------------------------------------------------------------------------
// Slave channel: one transfer per received byte (tuser = 0, tdata = byte), or
// a reply timeout (tuser = 1). Master channel: one transfer per frame, on the
// 25th byte or on a timeout; tuser = frame ok, tdata = raw measurement words,
// all zero when the frame failed (timeout or CRC mismatch).
// A CRC-16 (reflected 0xA001, seed 0xFFFF) runs over bytes 0 to 22 and is
// checked against bytes 23 (low) and 24 (high).
// Throughput: one byte per cycle while the master side does not stall, set by
// the single CRC byte step between the input register and the result register.
// Result path: the last byte is taken into the input register, and the result
// is then shown from the result register.
// Reset: synchronous, active low; clears both stages and restarts the frame.
// Stall: while the result register waits, the input register still takes
// one byte; after that tready drops until the result is taken.
// ----------------------------------------------------------------------------
module meter_reply_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    input  logic         i_s_axis_tuser,   // [0] kind
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // [15:0] voltage, [47:16] current,
                                           // [79:48] power, [111:80] energy,
                                           // [127:112] frequency,
                                           // [143:128] power factor,
                                           // [159:144] alarm word
    output logic         o_m_axis_tuser    // [0] frame_ok
);
    import mrfp_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    logic     r_in_kind;
    logic [7:0] r_in_byte;
    logic     r_out_valid;
    logic     n_out_valid;
    t_result  r_out;
    t_result  w_core;
    logic     w_adv;
    logic     w_in_acc;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    mrfp_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && w_adv),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .o_result (w_core)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = w_adv ? w_core.valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_adv) begin
            r_out <= w_core;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.ok;
    assign o_m_axis_tdata  = {r_out.alarm, r_out.power_factor, r_out.frequency,
                              r_out.energy, r_out.power, r_out.current, r_out.voltage};

`ifndef NO_ASSERTIONS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("failed frame carries nonzero values");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while both stages are full");

    a_timeout_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_in_kind == KIND_TIMEOUT) |=> (r_out_valid && !r_out.ok))
        else $error("timeout did not give a failed result");
`endif

endmodule
